>>> rtl/mm3_pkg.sv
// Shared types, constants and the microcode table for the MurmurHash3 x64_128 hasher.
`timescale 1ns / 1ps
package mm3_pkg;

  // Bytes in one mixing block.
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned FILL_W      = $clog2(BLOCK_BYTES);

  // Mixing constants of the published scheme.
  localparam logic [63:0] MUL_A     = 64'h87c37b91114253d5;
  localparam logic [63:0] MUL_B     = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_A    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_B    = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] LANE1_ADD = 64'd1390208809;
  localparam logic [63:0] LANE2_ADD = 64'd944331445;

  // Microcode addresses.
  localparam int unsigned PC_W       = 6;
  localparam logic [PC_W-1:0] PC_BLOCK = 6'd0;
  localparam logic [PC_W-1:0] PC_TAIL  = 6'd12;
  localparam logic [PC_W-1:0] PC_FINAL = 6'd22;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_BYTE,     // store one message byte
    OP_K_W1,     // k = low word of the block store
    OP_K_W2,     // k = high word of the block store
    OP_K_H1,     // k = lane one
    OP_K_H2,     // k = lane two
    OP_MUL,      // k = k * constant, from 32-bit partial products
    OP_ROT31,    // k = rotl(k, 31)
    OP_ROT33,    // k = rotl(k, 33)
    OP_XSH,      // k ^= k >> 33
    OP_H1_MIX,   // h1 = rotl(h1 ^ k, 27) + h2
    OP_H1_MA,    // h1 = h1 * 5 + LANE1_ADD
    OP_H2_MIX,   // h2 = rotl(h2 ^ k, 31) + h1
    OP_H2_MA,    // h2 = h2 * 5 + LANE2_ADD
    OP_H1_XK,    // h1 ^= k
    OP_H2_XK,    // h2 ^= k
    OP_XTOT,     // both lanes ^= byte total
    OP_H1_ADD,   // h1 += h2
    OP_H2_ADD,   // h2 += h1
    OP_H1_K,     // h1 = k
    OP_H2_K,     // h2 = k
    OP_EMIT      // capture h1 as the result and restart from the seed
  } op_t;

  // Multiplier constant select.
  typedef enum logic [1:0] {
    MS_A,
    MS_B,
    MS_FA,
    MS_FB
  } mul_sel_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t msel;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;   // next byte completes a block
    logic fill_empty;  // no tail bytes waiting
    logic mul_done;    // multiply finishes this cycle
  } dp_stat_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t msel;
    logic     last;
  } ucode_t;

  // Microcode: block mix, then tail mix, then finalization.
  function automatic ucode_t mm3_ucode(input logic [PC_W-1:0] pc);
    ucode_t u;
    u = '{op: OP_NOP, msel: MS_A, last: 1'b0};
    case (pc)
      6'd0:  u.op = OP_K_W1;
      6'd1:  begin u.op = OP_MUL; u.msel = MS_A; end
      6'd2:  u.op = OP_ROT31;
      6'd3:  begin u.op = OP_MUL; u.msel = MS_B; end
      6'd4:  u.op = OP_H1_MIX;
      6'd5:  u.op = OP_H1_MA;
      6'd6:  u.op = OP_K_W2;
      6'd7:  begin u.op = OP_MUL; u.msel = MS_B; end
      6'd8:  u.op = OP_ROT33;
      6'd9:  begin u.op = OP_MUL; u.msel = MS_A; end
      6'd10: u.op = OP_H2_MIX;
      6'd11: begin u.op = OP_H2_MA; u.last = 1'b1; end
      6'd12: u.op = OP_K_W1;
      6'd13: begin u.op = OP_MUL; u.msel = MS_A; end
      6'd14: u.op = OP_ROT31;
      6'd15: begin u.op = OP_MUL; u.msel = MS_B; end
      6'd16: u.op = OP_H1_XK;
      6'd17: u.op = OP_K_W2;
      6'd18: begin u.op = OP_MUL; u.msel = MS_B; end
      6'd19: u.op = OP_ROT33;
      6'd20: begin u.op = OP_MUL; u.msel = MS_A; end
      6'd21: u.op = OP_H2_XK;
      6'd22: u.op = OP_XTOT;
      6'd23: u.op = OP_H1_ADD;
      6'd24: u.op = OP_H2_ADD;
      6'd25: u.op = OP_K_H1;
      6'd26: u.op = OP_XSH;
      6'd27: begin u.op = OP_MUL; u.msel = MS_FA; end
      6'd28: u.op = OP_XSH;
      6'd29: begin u.op = OP_MUL; u.msel = MS_FB; end
      6'd30: u.op = OP_XSH;
      6'd31: u.op = OP_H1_K;
      6'd32: u.op = OP_K_H2;
      6'd33: u.op = OP_XSH;
      6'd34: begin u.op = OP_MUL; u.msel = MS_FA; end
      6'd35: u.op = OP_XSH;
      6'd36: begin u.op = OP_MUL; u.msel = MS_FB; end
      6'd37: u.op = OP_XSH;
      6'd38: u.op = OP_H2_K;
      6'd39: begin u.op = OP_H1_ADD; u.last = 1'b1; end
      default: u.op = OP_NOP;
    endcase
    return u;
  endfunction

endpackage

>>> rtl/murmur3_x64_128_stream_hash.sv
// Top level of the streaming MurmurHash3 x64_128 hasher.
// A byte is taken whenever the input is not stalled; the sixteenth byte of a block then
// stalls the input during the block mix on one shared 32x32 multiplier (four multiplies
// and eight other steps), so no new byte is taken until the block is mixed. A finish
// transaction runs any tail mix and finalization, then gives its result. Synchronous,
// active-low reset clears the seed to zero, both lanes, the byte count and the fill level.
`timescale 1ns / 1ps
module murmur3_x64_128_stream_hash
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The seed register is always free to take a write.
  assign cfg_ready = 1'b1;

  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mm3_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_data_byte (in_data_byte),
    .cfg_we       (cfg_valid),
    .cfg_seed     (cfg_seed),
    .stat         (stat),
    .hash_value   (out_hash_value)
  );

endmodule

>>> rtl/mm3_dp.sv
// Datapath: lanes, block store, byte count and a shared 32x32 multiplier.
`timescale 1ns / 1ps
module mm3_dp
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_we,
  input  logic [31:0] cfg_seed,
  output dp_stat_t    stat,
  output logic [63:0] hash_value
);

  logic [31:0]       seed_r;
  logic [63:0]       h1_r, h1_nxt;
  logic [63:0]       h2_r, h2_nxt;
  logic [63:0]       k_r, k_nxt;
  logic [63:0]       total_r;
  logic [FILL_W-1:0] fill_r;
  logic [7:0]        store_r [BLOCK_BYTES];
  logic [1:0]        mcnt_r;
  logic [63:0]       prod_r;
  logic [63:0]       acc_r;
  logic [63:0]       res_r;
  logic [63:0]       w1, w2;
  logic [63:0]       mconst;
  logic [31:0]       mop_a, mop_b;
  logic [63:0]       seed_wide;
  logic [63:0]       h1_xk, h2_xk;

  assign seed_wide = {{32{seed_r[31]}}, seed_r};

  // Gather the waiting bytes as two little-endian words; an empty fill means a full block.
  always_comb begin
    w1 = '0;
    w2 = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (fill_r == '0 || FILL_W'(i) < fill_r) begin
        if (i < 8) w1[8*i +: 8] = store_r[i];
        else       w2[8*(i-8) +: 8] = store_r[i];
      end
    end
  end

  // Multiplier constant and 32-bit operand selection for the partial products.
  always_comb begin
    case (cmd.msel)
      MS_A:    mconst = MUL_A;
      MS_B:    mconst = MUL_B;
      MS_FA:   mconst = FMIX_A;
      MS_FB:   mconst = FMIX_B;
      default: mconst = MUL_A;
    endcase
    case (mcnt_r)
      2'd0:    begin mop_a = k_r[31:0];  mop_b = mconst[31:0];  end
      2'd1:    begin mop_a = k_r[31:0];  mop_b = mconst[63:32]; end
      2'd2:    begin mop_a = k_r[63:32]; mop_b = mconst[31:0];  end
      default: begin mop_a = k_r[31:0];  mop_b = mconst[31:0];  end
    endcase
  end

  assign h1_xk = h1_r ^ k_r;
  assign h2_xk = h2_r ^ k_r;

  // Next values of the work register and the lanes.
  always_comb begin
    k_nxt  = k_r;
    h1_nxt = h1_r;
    h2_nxt = h2_r;
    case (cmd.op)
      OP_K_W1:   k_nxt = w1;
      OP_K_W2:   k_nxt = w2;
      OP_K_H1:   k_nxt = h1_r;
      OP_K_H2:   k_nxt = h2_r;
      OP_MUL: begin
        if (mcnt_r == 2'd3) k_nxt = acc_r + {prod_r[31:0], 32'b0};
      end
      OP_ROT31:  k_nxt = {k_r[32:0], k_r[63:33]};
      OP_ROT33:  k_nxt = {k_r[30:0], k_r[63:31]};
      OP_XSH:    k_nxt = k_r ^ {33'b0, k_r[63:33]};
      OP_H1_MIX: h1_nxt = {h1_xk[36:0], h1_xk[63:37]} + h2_r;
      OP_H1_MA:  h1_nxt = {h1_r[61:0], 2'b0} + h1_r + LANE1_ADD;
      OP_H2_MIX: h2_nxt = {h2_xk[32:0], h2_xk[63:33]} + h1_r;
      OP_H2_MA:  h2_nxt = {h2_r[61:0], 2'b0} + h2_r + LANE2_ADD;
      OP_H1_XK:  h1_nxt = h1_xk;
      OP_H2_XK:  h2_nxt = h2_xk;
      OP_XTOT: begin
        h1_nxt = h1_r ^ total_r;
        h2_nxt = h2_r ^ total_r;
      end
      OP_H1_ADD: h1_nxt = h1_r + h2_r;
      OP_H2_ADD: h2_nxt = h2_r + h1_r;
      OP_H1_K:   h1_nxt = k_r;
      OP_H2_K:   h2_nxt = k_r;
      OP_EMIT: begin
        h1_nxt = seed_wide;
        h2_nxt = seed_wide;
      end
      default: ;
    endcase
  end

  // Control state: seed, lanes, count, fill level and multiply step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      h1_r    <= '0;
      h2_r    <= '0;
      total_r <= '0;
      fill_r  <= '0;
      mcnt_r  <= '0;
    end else begin
      h1_r <= h1_nxt;
      h2_r <= h2_nxt;
      if (cmd.op == OP_MUL) mcnt_r <= mcnt_r + 2'd1;
      if (cmd.op == OP_BYTE) begin
        fill_r  <= fill_r + FILL_W'(1);
        total_r <= total_r + 64'd1;
      end else if (cmd.op == OP_EMIT) begin
        fill_r  <= '0;
        total_r <= '0;
      end
      // A seed write on an empty message also reloads both lanes.
      if (cfg_we) begin
        seed_r <= cfg_seed;
        if (total_r == '0 && fill_r == '0) begin
          h1_r <= {{32{cfg_seed[31]}}, cfg_seed};
          h2_r <= {{32{cfg_seed[31]}}, cfg_seed};
        end
      end
    end
  end

  // Payload registers: work word, partial products, block store and result.
  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    prod_r <= 64'(mop_a) * 64'(mop_b);
    if (mcnt_r == 2'd1)      acc_r <= prod_r;
    else if (mcnt_r == 2'd2) acc_r <= acc_r + {prod_r[31:0], 32'b0};
    if (cmd.op == OP_BYTE) store_r[fill_r] <= in_data_byte;
    if (cmd.op == OP_EMIT) res_r <= h1_r;
  end

  // The step counter only reaches its last value while a multiply runs.
  assign stat.fill_last  = (fill_r == {FILL_W{1'b1}});
  assign stat.fill_empty = (fill_r == '0);
  assign stat.mul_done   = (mcnt_r == 2'd3);
  assign hash_value      = res_r;

endmodule

>>> rtl/mm3_ctrl.sv
// Controller: takes transactions, steps the microcode and hands out results.
`timescale 1ns / 1ps
module mm3_ctrl
  import mm3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            out_valid_r, out_valid_nxt;
  ucode_t          uc;

  assign uc = mm3_ucode(pc_r);

  // Next state, microcode address and datapath command.
  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '{op: OP_NOP, msel: MS_A};
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_kind) begin
            cmd.op = OP_BYTE;
            if (stat.fill_last) begin
              state_nxt = ST_RUN;
              pc_nxt    = PC_BLOCK;
            end
          end else begin
            state_nxt = ST_RUN;
            pc_nxt    = stat.fill_empty ? PC_FINAL : PC_TAIL;
          end
        end
      end
      ST_RUN: begin
        cmd.op   = uc.op;
        cmd.msel = uc.msel;
        if (uc.op != OP_MUL || stat.mul_done) begin
          pc_nxt = pc_r + PC_W'(1);
          if (uc.last) state_nxt = (pc_r == PC_BLOCK + PC_TAIL - PC_W'(1)) ? ST_IDLE : ST_OUT;
        end
      end
      ST_OUT: begin
        // Emit once the output register is free or being taken.
        if (!(out_valid_r && out_stall)) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
